// ===== src/sorted_priority_queue_top_assert.svh =====
// assertion macros for the sorted priority queue top level
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SPQ_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted queue check failed");

// next-cycle implication, checked out of reset
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted queue check failed");

`endif

// ===== src/spq_pkg.sv =====
// types and constants shared by the sorted priority queue modules
package spq_pkg;

	localparam int DEPTH   = 16;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int LEVEL_W = 4;
	localparam int ROLE_W  = 2;
	localparam int FILL_W  = 5;

	// request codes
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_POP    = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	// status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [ROLE_W-1:0]  role;
	} entry_t;

	// control broadcast to every cell
	typedef struct packed {
		logic   insert;
		logic   pop;
		entry_t key;
	} cell_ctrl_t;

endpackage

// ===== src/spq_if.sv =====
// request and response channel interfaces of the sorted priority queue
interface spq_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [3:0] key_level;
	logic [1:0] entry_role;

	modport source (output valid, req_type, key_level, entry_role, input ready);
	modport sink (input valid, req_type, key_level, entry_role, output ready);
endinterface

interface spq_rsp_if;
	logic       valid;
	logic       ready;
	logic       out_valid;
	logic [3:0] out_level;
	logic [1:0] out_role;
	logic [1:0] status;
	logic [4:0] fill_count;

	modport source (output valid, out_valid, out_level, out_role, status, fill_count,
		input ready);
	modport sink (input valid, out_valid, out_level, out_role, status, fill_count,
		output ready);
endinterface

// ===== src/spq_cell.sv =====
// one slot of the sorted chain: keeps, takes the new entry, or shifts
module spq_cell (
	input  logic                clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic                occupied,
	input  logic                left_above,
	input  spq_pkg::entry_t     left_entry,
	input  spq_pkg::entry_t     right_entry,
	output spq_pkg::entry_t     entry,
	output logic                above
);

	spq_pkg::entry_t entry_q;

	// this slot ranks strictly ahead of the incoming key
	assign above = occupied && (entry_q.level > ctrl.key.level);
	assign entry = entry_q;

	// slot update on insert or pop
	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (!above) begin
				if (left_above) begin
					entry_q <= ctrl.key;
				end else begin
					entry_q <= left_entry;
				end
			end
		end else if (ctrl.pop) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ===== src/sorted_priority_queue_top.sv =====
// Sorted priority queue of spq_pkg::DEPTH entries held in a chain of slot cells,
// front (highest level, newest among equals) in cell 0. Every cell compares its
// entry with the incoming key at once and shifts, so an insert, pop or clear
// request is accepted every cycle unless the output stalls; its response comes
// out of an output register in the cycle after acceptance and the next request
// is taken while that response is being delivered. Slot contents are not cleared
// at reset, only the fill count is, so the queue is usable right after reset.
`include "sorted_priority_queue_top_assert.svh"

module sorted_priority_queue_top (
	input logic       clk,
	input logic       arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	logic [spq_pkg::CNT_W-1:0] count_q;
	logic                      res_valid_q;
	logic                      res_out_valid_q;
	spq_pkg::entry_t           res_entry_q;
	logic [1:0]                res_status_q;

	logic                      accept;
	logic                      full;
	logic                      empty;
	spq_pkg::cell_ctrl_t       ctrl;
	spq_pkg::entry_t           cell_entry [spq_pkg::DEPTH];
	logic                      cell_above [spq_pkg::DEPTH];

	logic                      chk_ins_full;
	logic                      chk_two_held;
	logic                      chk_status_full;

	// request handshake and queue state
	assign req.ready = !res_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == spq_pkg::CNT_W'(spq_pkg::DEPTH));
	assign empty     = (count_q == '0);

	// broadcast control to the chain
	always_comb begin
		ctrl.insert    = accept && (req.req_type == spq_pkg::REQ_INSERT) && !full;
		ctrl.pop       = accept && (req.req_type == spq_pkg::REQ_POP) && !empty;
		ctrl.key.level = req.key_level;
		ctrl.key.role  = req.entry_role;
	end

	// chain of slot cells
	genvar i;
	generate
		for (i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
			logic            left_above;
			spq_pkg::entry_t left_entry;
			spq_pkg::entry_t right_entry;

			if (i == 0) begin : g_first
				assign left_above = 1'b1;
				assign left_entry = '0;
			end else begin : g_mid
				assign left_above = cell_above[i-1];
				assign left_entry = cell_entry[i-1];
			end

			if (i == spq_pkg::DEPTH - 1) begin : g_last
				assign right_entry = '0;
			end else begin : g_inner
				assign right_entry = cell_entry[i+1];
			end

			spq_cell u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.occupied    (count_q > spq_pkg::CNT_W'(i)),
				.left_above  (left_above),
				.left_entry  (left_entry),
				.right_entry (right_entry),
				.entry       (cell_entry[i]),
				.above       (cell_above[i])
			);
		end
	endgenerate

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			case (req.req_type)
				spq_pkg::REQ_INSERT: begin
					if (!full) count_q <= count_q + 1'b1;
				end
				spq_pkg::REQ_POP: begin
					if (!empty) count_q <= count_q - 1'b1;
				end
				spq_pkg::REQ_CLEAR: begin
					count_q <= '0;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	// response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_out_valid_q <= ctrl.pop;
			res_entry_q     <= ctrl.pop ? cell_entry[0] : '0;
			case (req.req_type)
				spq_pkg::REQ_INSERT: res_status_q <= full ? spq_pkg::STATUS_FULL
					: spq_pkg::STATUS_OK;
				spq_pkg::REQ_POP: res_status_q <= empty ? spq_pkg::STATUS_EMPTY
					: spq_pkg::STATUS_OK;
				default: res_status_q <= spq_pkg::STATUS_OK;
			endcase
		end
	end

	assign rsp.valid      = res_valid_q;
	assign rsp.out_valid  = res_out_valid_q;
	assign rsp.out_level  = res_entry_q.level;
	assign rsp.out_role   = res_entry_q.role;
	assign rsp.status     = res_status_q;
	assign rsp.fill_count = spq_pkg::FILL_W'(count_q);

	// terms used by the checks
	assign chk_ins_full    = accept && (req.req_type == spq_pkg::REQ_INSERT) && full;
	assign chk_two_held    = (count_q >= spq_pkg::CNT_W'(2));
	assign chk_status_full = (res_status_q == spq_pkg::STATUS_FULL);

	// checks
	`SPQ_ASSERT_SAME(a_count_bound, 1'b1, count_q <= spq_pkg::CNT_W'(spq_pkg::DEPTH))
	`SPQ_ASSERT_SAME(a_front_sorted, chk_two_held, cell_entry[0].level >= cell_entry[1].level)
	`SPQ_ASSERT_NEXT(a_full_refused, chk_ins_full, chk_status_full && $stable(count_q))
	`SPQ_ASSERT_NEXT(a_pop_count, ctrl.pop, count_q == $past(count_q) - 1'b1 && res_out_valid_q)

endmodule

// ===== tb/sorted_priority_queue_top_tb.sv =====
// self-checking testbench for the sorted priority queue top level
module sorted_priority_queue_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// request code that leaves the queue unchanged
	localparam logic [1:0] REQ_SPARE = 2'd3;
	localparam int RANDOM_ITEMS = 1650;

	typedef enum int {PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_e;

	typedef struct {
		logic [1:0] kind;
		logic [3:0] level;
		logic [1:0] role;
		pace_e      pace;
		bit         drain;
	} pq_req_t;

	typedef struct {
		logic       out_valid;
		logic [3:0] level;
		logic [1:0] role;
		logic [1:0] status;
		logic [4:0] fill;
	} pq_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic       drv_valid = 1'b0;
	logic [1:0] drv_type = spq_pkg::REQ_INSERT;
	logic [3:0] drv_level = '0;
	logic [1:0] drv_role = '0;
	logic       rcv_ready = 1'b0;
	pace_e      cur_pace = PACE_FREE;

	pq_req_t pending_q[$];
	pq_rsp_t expected_q[$];
	int      err_count = 0;

	// shadow copy of the queue contents
	spq_pkg::entry_t slot_img[spq_pkg::DEPTH];
	int unsigned     fill_img = 0;

	spq_req_if req_ch();
	spq_rsp_if rsp_ch();

	assign req_ch.valid      = drv_valid;
	assign req_ch.req_type   = drv_type;
	assign req_ch.key_level  = drv_level;
	assign req_ch.entry_role = drv_role;
	assign rsp_ch.ready      = rcv_ready;

	sorted_priority_queue_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int send_idle_pct(input pace_e p);
		case (p)
			PACE_SEND_IDLE: return 58;
			PACE_BOTH:      return 15;
			default:        return 0;
		endcase
	endfunction

	function automatic int recv_stall_pct(input pace_e p);
		case (p)
			PACE_RECV_STALL: return 58;
			PACE_BOTH:       return 15;
			default:         return 0;
		endcase
	endfunction

	// apply one request to the shadow queue and return the response it gives
	function automatic pq_rsp_t queue_model(input logic [1:0] kind, input logic [3:0] lvl,
		input logic [1:0] role);
		pq_rsp_t     r;
		int unsigned pos;
		r = '{out_valid: 1'b0, level: '0, role: '0, status: spq_pkg::STATUS_OK, fill: '0};
		case (kind)
			spq_pkg::REQ_INSERT: begin
				if (fill_img >= spq_pkg::DEPTH) begin
					r.status = spq_pkg::STATUS_FULL;
				end else begin
					// new entry goes ahead of the first entry not above it
					pos = fill_img;
					for (int i = 0; i < fill_img; i++)
						if (pos == fill_img && slot_img[i].level <= lvl)
							pos = i;
					for (int i = fill_img; i > pos; i--)
						slot_img[i] = slot_img[i-1];
					slot_img[pos] = {lvl, role};
					fill_img++;
				end
			end
			spq_pkg::REQ_POP: begin
				if (fill_img == 0) begin
					r.status = spq_pkg::STATUS_EMPTY;
				end else begin
					r.out_valid = 1'b1;
					r.level = slot_img[0].level;
					r.role = slot_img[0].role;
					for (int i = 1; i < fill_img; i++)
						slot_img[i-1] = slot_img[i];
					fill_img--;
				end
			end
			spq_pkg::REQ_CLEAR: begin
				fill_img = 0;
			end
			default: begin
			end
		endcase
		r.fill = fill_img[4:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		err_count++;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		pq_req_t nxt;
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_type <= spq_pkg::REQ_INSERT;
			drv_level <= '0;
			drv_role <= '0;
			cur_pace <= PACE_FREE;
		end else begin
			// predict the request taken at this edge
			if (drv_valid && req_ch.ready)
				expected_q.push_back(queue_model(drv_type, drv_level, drv_role));
			// offer the next request or idle
			if (!drv_valid || req_ch.ready) begin
				if (pending_q.size() != 0 && !(pending_q[0].drain && expected_q.size() != 0)
					&& $urandom_range(99) >= send_idle_pct(pending_q[0].pace)) begin
					nxt = pending_q.pop_front();
					drv_valid <= 1'b1;
					drv_type <= nxt.kind;
					drv_level <= nxt.level;
					drv_role <= nxt.role;
					cur_pace <= nxt.pace;
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor and checker
	always @(posedge clk or negedge arst_n) begin
		pq_rsp_t want;
		if (!arst_n) begin
			rcv_ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("response with none pending, level",
						8'(rsp_ch.out_level), 8'h0);
				end else begin
					want = expected_q.pop_front();
					if (rsp_ch.out_valid !== want.out_valid)
						report_mismatch("out_valid", 8'(rsp_ch.out_valid), 8'(want.out_valid));
					if (rsp_ch.out_level !== want.level)
						report_mismatch("out_level", 8'(rsp_ch.out_level), 8'(want.level));
					if (rsp_ch.out_role !== want.role)
						report_mismatch("out_role", 8'(rsp_ch.out_role), 8'(want.role));
					if (rsp_ch.status !== want.status)
						report_mismatch("status", 8'(rsp_ch.status), 8'(want.status));
					if (rsp_ch.fill_count !== want.fill)
						report_mismatch("fill_count", 8'(rsp_ch.fill_count), 8'(want.fill));
				end
			end
			rcv_ready <= ($urandom_range(99) >= recv_stall_pct(cur_pace));
		end
	end

	task automatic add_req(input logic [1:0] kind, input logic [3:0] lvl, input logic [1:0] role,
		input pace_e p, input bit drain);
		pending_q.push_back('{kind: kind, level: lvl, role: role, pace: p, drain: drain});
	endtask

	// stimulus, reset and end of run
	initial begin
		logic [3:0] fill_levels[16];
		int         taken;
		int         seg;
		int         seg_len;
		int         ins_pct;
		int         lvl_hi;
		int         roll;
		pace_e      p;
		logic [1:0] kind;

		fill_levels = '{4'd0, 4'd15, 4'd7, 4'd7, 4'd3, 4'd15, 4'd0, 4'd9,
			4'd12, 4'd1, 4'd7, 4'd5, 4'd15, 4'd2, 4'd10, 4'd0};

		// directed: empty pop, spare code, fill to full with ties, refusal, pops, clear, empty pop
		add_req(spq_pkg::REQ_POP, 4'd15, 2'd3, PACE_FREE, 1'b0);
		add_req(REQ_SPARE, 4'd15, 2'd3, PACE_FREE, 1'b0);
		for (int i = 0; i < 16; i++)
			add_req(spq_pkg::REQ_INSERT, fill_levels[i], i[1:0], PACE_FREE, 1'b0);
		add_req(spq_pkg::REQ_INSERT, 4'd15, 2'd3, PACE_FREE, 1'b0);
		add_req(spq_pkg::REQ_POP, 4'd0, 2'd0, PACE_FREE, 1'b0);
		add_req(spq_pkg::REQ_POP, 4'd0, 2'd0, PACE_FREE, 1'b0);
		add_req(spq_pkg::REQ_CLEAR, 4'd0, 2'd0, PACE_FREE, 1'b0);
		add_req(spq_pkg::REQ_POP, 4'd0, 2'd0, PACE_FREE, 1'b0);

		// random segments, each opening with a pause until the queue has answered all
		taken = 0;
		seg = 0;
		while (taken < RANDOM_ITEMS) begin
			p = (seg < 4) ? pace_e'(seg) : pace_e'($urandom_range(3));
			seg_len = $urandom_range(120, 40);
			case ($urandom_range(2))
				0:       ins_pct = 72;
				1:       ins_pct = 25;
				default: ins_pct = 48;
			endcase
			lvl_hi = ($urandom_range(2) == 0) ? 3 : 15;
			for (int i = 0; i < seg_len; i++) begin
				roll = $urandom_range(99);
				if (roll < 2)
					kind = spq_pkg::REQ_CLEAR;
				else if (roll < 4)
					kind = REQ_SPARE;
				else if (roll < 4 + ins_pct)
					kind = spq_pkg::REQ_INSERT;
				else
					kind = spq_pkg::REQ_POP;
				add_req(kind, 4'($urandom_range(lvl_hi)), 2'($urandom_range(3)), p, i == 0);
				if (kind != REQ_SPARE)
					taken++;
			end
			seg++;
		end

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_q.size() != 0 || drv_valid || expected_q.size() != 0) begin
			@(posedge clk);
			#1;
		end
		repeat (4) @(posedge clk);
		if (err_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/spq_pkg.sv
src/spq_if.sv
src/spq_cell.sv
src/sorted_priority_queue_top.sv
tb/sorted_priority_queue_top_tb.sv
